// ===== rtl/spectral_frequency_stability_gate_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spectral frequency-stability gate
// Clocked on clk_i, disabled while rst_ni is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_FREQUENCY_STABILITY_GATE_TOP_DEFINES_SVH
`define SPECTRAL_FREQUENCY_STABILITY_GATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SFSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define SFSG_NEVER(lbl, expr, msg) `SFSG_ASSERT(lbl, !(expr), msg)
`else
`define SFSG_ASSERT(lbl, prop, msg)
`define SFSG_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/sfsg_pkg.sv =====
// ----------------------------------------------------------------------------
// sfsg_pkg
// Shared constants and types of the spectral frequency-stability gate.
// ----------------------------------------------------------------------------
package sfsg_pkg;

  localparam int MaxBins   = 1024;
  localparam int BinW      = 10;
  localparam int Window    = 6;
  localparam int SlotW     = 3;
  localparam int RingDepth = Window * MaxBins;
  localparam int RingAw    = SlotW + BinW;
  localparam int SumW      = 28;
  localparam int DataW     = 24;
  localparam int ScaleW    = 16;
  localparam int CntW      = 11;
  localparam int NumW      = 28;
  localparam int StepCntW  = 4;
  localparam int RingW     = 3 * DataW;
  localparam int BinMemW   = SumW + DataW;

  localparam logic [1:0] CfgBinCount  = 2'd0;
  localparam logic [1:0] CfgGateMode  = 2'd1;
  localparam logic [1:0] CfgFreqLimit = 2'd2;

  localparam logic [1:0] ModeNoisy  = 2'd1;
  localparam logic [1:0] ModeStable = 2'd2;

  // two quotient bits per cycle
  localparam logic [StepCntW-1:0] MeanCycles  = 4'd14;
  localparam logic [StepCntW-1:0] ScaleCycles = 4'd8;

  typedef struct packed {
    logic                start;
    logic [DataW-1:0]    divisor;
    logic [DataW-1:0]    rem;
    logic [NumW-1:0]     num;
    logic [StepCntW-1:0] cycles;
  } div_req_t;

endpackage

// ===== rtl/sfsg_ram.sv =====
// ----------------------------------------------------------------------------
// sfsg_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sfsg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfsg_div.sv =====
// ----------------------------------------------------------------------------
// sfsg_div
// Restoring divider, two quotient bits per cycle, preset partial remainder.
// ----------------------------------------------------------------------------
module sfsg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfsg_pkg::div_req_t            req_i,
  output logic                          done_o,
  output logic [sfsg_pkg::NumW-1:0]     quot_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [sfsg_pkg::StepCntW-1:0]     cnt_q;
  logic [sfsg_pkg::DataW-1:0]        rem_q, rem_d;
  logic [sfsg_pkg::DataW-1:0]        div_q;
  logic [sfsg_pkg::NumW-1:0]         num_q, num_d;
  logic [sfsg_pkg::NumW-1:0]         quot_q, quot_d;
  logic [sfsg_pkg::DataW:0]          r1, r1s, r2, r2s;
  logic                              ge1, ge2;

  always_comb begin
    r1     = {rem_q, num_q[sfsg_pkg::NumW-1]};
    ge1    = r1 >= {1'b0, div_q};
    r1s    = ge1 ? r1 - {1'b0, div_q} : r1;
    r2     = {r1s[sfsg_pkg::DataW-1:0], num_q[sfsg_pkg::NumW-2]};
    ge2    = r2 >= {1'b0, div_q};
    r2s    = ge2 ? r2 - {1'b0, div_q} : r2;
    rem_d  = r2s[sfsg_pkg::DataW-1:0];
    num_d  = {num_q[sfsg_pkg::NumW-3:0], 2'b00};
    quot_d = {quot_q[sfsg_pkg::NumW-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.cycles;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == sfsg_pkg::StepCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem;
      div_q  <= req_i.divisor;
      num_q  <= req_i.num;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      num_q  <= num_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/spectral_frequency_stability_gate_top.sv =====
// ----------------------------------------------------------------------------
// spectral_frequency_stability_gate_top
// Delays phase-vocoder bins six frames and gates each amplitude by the mean
// frequency change of that bin over the following frames.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_stall_o    func, amplitude, frequency
// out       output     out_valid_o / out_stall_i  amp_out .. data_end
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One word at a time: each word passes accept, memory read, mean division,
// gate, scale division (ramped bins only) and output load, and the next word
// is accepted only after that. The shared divider serves both divisions.
// A warm-up sample stops after the memory read; a drain word of the last held
// frame skips the mean division.
// A drain word with no frame held finishes in its accept cycle.
// Reset clears control state only; the rings and per-bin stores are not
// cleared, so no clearing pass runs. The output register lets the next word
// be accepted while a result still waits; a stalled output holds the block
// only at its final load step.
// ----------------------------------------------------------------------------
`include "spectral_frequency_stability_gate_top_defines.svh"

module spectral_frequency_stability_gate_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [23:0] amplitude_i,
  input  logic [23:0] frequency_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] amp_out_o,
  output logic [23:0] freq_out_o,
  output logic [9:0]  bin_out_o,
  output logic        frame_end_o,
  output logic        data_end_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int DataW  = sfsg_pkg::DataW;
  localparam int SumW   = sfsg_pkg::SumW;
  localparam int BinW   = sfsg_pkg::BinW;
  localparam int SlotW  = sfsg_pkg::SlotW;
  localparam int CntW   = sfsg_pkg::CntW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCalc = 3'd1;
  localparam logic [2:0] StDiv1 = 3'd2;
  localparam logic [2:0] StGate = 3'd3;
  localparam logic [2:0] StDiv2 = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  // configuration registers
  logic [CntW-1:0]  bin_count_q;
  logic [1:0]       gate_mode_q;
  logic [DataW-1:0] freq_limit_q;

  // stream control
  logic [2:0]       state_q, state_d;
  logic [BinW-1:0]  pos_q, pos_d;
  logic [SlotW-1:0] pend_q, pend_d;
  logic [SlotW-1:0] head_q, head_d;

  // word in flight
  logic                      func_q;
  logic [DataW-1:0]          amp_in_q, freq_in_q;
  logic [BinW-1:0]           bin_q;
  logic                      last_q;
  logic [SlotW-1:0]          p_q;
  logic [sfsg_pkg::RingAw-1:0] ring_addr_q;
  logic [DataW-1:0]          res_amp_q, res_freq_q;
  logic                      res_fend_q, res_dend_q;
  logic [SumW-1:0]           mean_q;

  // output register
  logic             ov_q;
  logic [DataW-1:0] oamp_q, ofreq_q;
  logic [BinW-1:0]  obin_q;
  logic             ofend_q, odend_q;

  logic                      accept;
  logic [CntW-1:0]           act;
  logic                      last_w;
  logic [SlotW:0]            slot_sum;
  logic [SlotW-1:0]          slot_w;
  logic [sfsg_pkg::RingW-1:0]   ring_rd, ring_wd;
  logic [sfsg_pkg::BinMemW-1:0] bin_rd, bin_wd;
  logic                      ring_we, bin_we;
  logic [DataW-1:0]          r_amp, r_freq, r_diff, b_lf, d;
  logic [SumW-1:0]           b_sum, sum;
  logic                      has_res;
  sfsg_pkg::div_req_t        div_req;
  logic                      div_done;
  logic [sfsg_pkg::NumW-1:0] quot;
  logic [DataW-1:0]          lim;
  logic [SumW-1:0]           lim_x, two_lim;
  logic [DataW+sfsg_pkg::ScaleW-1:0] prod;
  logic                      fin_load;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);

  // active bin count, saturated to one..MaxBins
  always_comb begin
    if (bin_count_q == '0) begin
      act = CntW'(1);
    end else if (bin_count_q > CntW'(sfsg_pkg::MaxBins)) begin
      act = CntW'(sfsg_pkg::MaxBins);
    end else begin
      act = bin_count_q;
    end
    last_w   = {1'b0, pos_q} >= act - CntW'(1);
    // drain reads the oldest held frame
    slot_sum = {1'b0, head_q} + (SlotW+1)'(sfsg_pkg::Window) - {1'b0, pend_q};
    if (func_i && slot_sum >= (SlotW+1)'(sfsg_pkg::Window)) begin
      slot_w = SlotW'(slot_sum - (SlotW+1)'(sfsg_pkg::Window));
    end else if (func_i) begin
      slot_w = slot_sum[SlotW-1:0];
    end else begin
      slot_w = head_q;
    end
  end

  // advance position, head and held-frame count at accept
  always_comb begin
    pos_d  = pos_q;
    pend_d = pend_q;
    head_d = head_q;
    if (accept) begin
      if (!func_i) begin
        if (last_w) begin
          pos_d  = '0;
          head_d = (head_q == SlotW'(sfsg_pkg::Window - 1)) ? '0 : head_q + 1'b1;
          if (pend_q < SlotW'(sfsg_pkg::Window)) begin
            pend_d = pend_q + 1'b1;
          end
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end else if (pend_q == '0) begin
        pos_d = '0;
      end else if (last_w) begin
        pos_d  = '0;
        pend_d = pend_q - 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  sfsg_ram #(
    .Width (sfsg_pkg::RingW),
    .Depth (sfsg_pkg::RingDepth),
    .AddrW (sfsg_pkg::RingAw)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_addr_q),
    .wdata_i (ring_wd),
    .re_i    (accept),
    .raddr_i ({slot_w, pos_q}),
    .rdata_o (ring_rd)
  );

  sfsg_ram #(
    .Width (sfsg_pkg::BinMemW),
    .Depth (sfsg_pkg::MaxBins),
    .AddrW (BinW)
  ) u_bin (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_q),
    .wdata_i (bin_wd),
    .re_i    (accept),
    .raddr_i (pos_q),
    .rdata_o (bin_rd)
  );

  // read-modify-write of the running deviation sum
  always_comb begin
    r_amp  = ring_rd[3*DataW-1:2*DataW];
    r_freq = ring_rd[2*DataW-1:DataW];
    r_diff = ring_rd[DataW-1:0];
    b_sum  = bin_rd[sfsg_pkg::BinMemW-1:DataW];
    b_lf   = bin_rd[DataW-1:0];
    d      = '0;
    sum    = '0;
    if (func_q) begin
      sum = b_sum - {4'b0, r_diff};
    end else if (p_q != '0) begin
      d   = (freq_in_q > b_lf) ? freq_in_q - b_lf : b_lf - freq_in_q;
      sum = b_sum + {4'b0, d};
      if (p_q >= SlotW'(sfsg_pkg::Window)) begin
        sum = sum - {4'b0, r_diff};
      end
    end
    ring_wd = {amp_in_q, freq_in_q, d};
    bin_wd  = func_q ? {sum, b_lf} : {sum, freq_in_q};
    ring_we = (state_q == StCalc) && !func_q;
    bin_we  = (state_q == StCalc);
    has_res = func_q || (p_q >= SlotW'(sfsg_pkg::Window));
  end

  // gate thresholds; a zero limit counts as one
  always_comb begin
    lim     = (freq_limit_q == '0) ? DataW'(1) : freq_limit_q;
    lim_x   = {4'b0, lim};
    two_lim = {3'b0, lim, 1'b0};
    prod    = res_amp_q * quot[sfsg_pkg::ScaleW-1:0];
  end

  // divider requests: mean in StCalc, scale in StGate
  always_comb begin
    div_req         = '0;
    div_req.divisor = DataW'(sfsg_pkg::Window);
    state_d         = state_q;
    case (state_q)
      StIdle: begin
        if (accept && !(func_i && pend_q == '0)) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        if (!has_res) begin
          state_d = StIdle;
        end else if (func_q && p_q == SlotW'(1)) begin
          state_d = StGate;
        end else begin
          div_req.start   = 1'b1;
          div_req.num     = sum;
          div_req.cycles  = sfsg_pkg::MeanCycles;
          div_req.divisor = func_q ? DataW'(p_q - 1'b1) : DataW'(sfsg_pkg::Window);
          state_d         = StDiv1;
        end
      end
      StDiv1: begin
        if (div_done) begin
          state_d = StGate;
        end
      end
      StGate: begin
        state_d         = StFin;
        div_req.divisor = lim;
        div_req.cycles  = sfsg_pkg::ScaleCycles;
        if (gate_mode_q == sfsg_pkg::ModeNoisy && mean_q > lim_x && mean_q < two_lim) begin
          div_req.start = 1'b1;
          div_req.rem   = DataW'(mean_q - lim_x);
          state_d       = StDiv2;
        end else if (gate_mode_q == sfsg_pkg::ModeStable && mean_q < lim_x &&
                     mean_q != '0) begin
          div_req.start = 1'b1;
          div_req.rem   = DataW'(lim_x - mean_q);
          state_d       = StDiv2;
        end
      end
      StDiv2: begin
        if (div_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (fin_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign fin_load = (state_q == StFin) && (!ov_q || !out_stall_i);

  sfsg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q  <= CntW'(513);
      gate_mode_q  <= '0;
      freq_limit_q <= DataW'(256);
      state_q      <= StIdle;
      pos_q        <= '0;
      pend_q       <= '0;
      head_q       <= '0;
      ov_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfsg_pkg::CfgBinCount:  bin_count_q  <= cfg_data_i[CntW-1:0];
          sfsg_pkg::CfgGateMode:  gate_mode_q  <= cfg_data_i[1:0];
          sfsg_pkg::CfgFreqLimit: freq_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      state_q <= state_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      head_q  <= head_d;
      if (fin_load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload of the word in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_i;
      amp_in_q    <= amplitude_i;
      freq_in_q   <= frequency_i;
      bin_q       <= pos_q;
      last_q      <= last_w;
      p_q         <= pend_q;
      ring_addr_q <= {slot_w, pos_q};
    end
    if (state_q == StCalc) begin
      res_amp_q  <= r_amp;
      res_freq_q <= r_freq;
      res_fend_q <= last_q;
      res_dend_q <= func_q && last_q && (p_q == SlotW'(1));
      mean_q     <= '0;
    end
    if (state_q == StDiv1 && div_done) begin
      mean_q <= quot;
    end
    // zero the bin where the gate closes
    if (state_q == StGate) begin
      if (gate_mode_q == sfsg_pkg::ModeNoisy && mean_q <= lim_x) begin
        res_amp_q <= '0;
      end else if (gate_mode_q == sfsg_pkg::ModeStable && mean_q >= lim_x) begin
        res_amp_q <= '0;
      end
    end
    if (state_q == StDiv2 && div_done) begin
      res_amp_q <= prod[DataW+sfsg_pkg::ScaleW-1:sfsg_pkg::ScaleW];
    end
    if (fin_load) begin
      oamp_q  <= res_amp_q;
      ofreq_q <= res_freq_q;
      obin_q  <= bin_q;
      ofend_q <= res_fend_q;
      odend_q <= res_dend_q;
    end
  end

  assign out_valid_o = ov_q;
  assign amp_out_o   = oamp_q;
  assign freq_out_o  = ofreq_q;
  assign bin_out_o   = obin_q;
  assign frame_end_o = ofend_q;
  assign data_end_o  = odend_q;

  `SFSG_NEVER(a_pend_range, pend_q > SlotW'(sfsg_pkg::Window), "held frames exceed window")
  `SFSG_NEVER(a_head_range, head_q >= SlotW'(sfsg_pkg::Window), "ring head out of range")
  `SFSG_ASSERT(a_dend_fend, out_valid_o |-> (!data_end_o || frame_end_o), "data end off frame end")
  `SFSG_ASSERT(a_div_state, div_done |-> (state_q == StDiv1 || state_q == StDiv2), "stray divider done")

endmodule

// ===== test/spectral_frequency_stability_gate_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectral_frequency_stability_gate_top_tb
// Streams framed amplitude/frequency bins through the gate under every gate
// mode and a range of limits and frame sizes, predicts each delayed and gated
// bin in a model of its own, and compares every output word field by field.
// ----------------------------------------------------------------------------
module spectral_frequency_stability_gate_top_tb;

  localparam int ItemTarget = 1900;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [23:0] amplitude;
  logic [23:0] frequency;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] amp_out;
  logic [23:0] freq_out;
  logic [9:0]  bin_out;
  logic        frame_end;
  logic        data_end;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [23:0] cfg_data;

  spectral_frequency_stability_gate_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .amplitude_i (amplitude),
    .frequency_i (frequency),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .amp_out_o   (amp_out),
    .freq_out_o  (freq_out),
    .bin_out_o   (bin_out),
    .frame_end_o (frame_end),
    .data_end_o  (data_end),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  typedef struct {
    logic [23:0] amp;
    logic [23:0] freq;
    logic [9:0]  bin;
    logic        fend;
    logic        dend;
  } gated_bin_t;

  gated_bin_t expected_bins[$];
  int         mismatches;
  int         words_sent;
  int         burst_left;

  // Shadow of the block: delay rings, per-bin deviation stores, frame control.
  logic [23:0] held_amp  [sfsg_pkg::RingDepth];
  logic [23:0] held_freq [sfsg_pkg::RingDepth];
  logic [23:0] held_diff [sfsg_pkg::RingDepth];
  logic [27:0] dev_sum   [sfsg_pkg::MaxBins];
  logic [23:0] prev_freq [sfsg_pkg::MaxBins];
  int unsigned bin_pos;
  int unsigned frames_held;
  int unsigned head_slot;
  logic [10:0] cfg_bins;
  logic [1:0]  cfg_mode;
  logic [23:0] cfg_limit;

  // Scale an amplitude by the mean deviation against the limit.
  function automatic logic [23:0] gate_amp(logic [23:0] a, logic [27:0] mean);
    logic [63:0] lim;
    logic [63:0] m;
    logic [63:0] scale;
    lim = (cfg_limit == 0) ? 64'd1 : 64'(cfg_limit);
    m   = 64'(mean);
    if (cfg_mode == sfsg_pkg::ModeNoisy) begin
      if (m > lim && m < 2 * lim) begin
        scale = ((m - lim) << 16) / lim;
        return 24'((64'(a) * scale) >> 16);
      end
      if (m <= lim) return 24'd0;
      return a;
    end
    if (cfg_mode == sfsg_pkg::ModeStable) begin
      if (m < lim) begin
        if (m == 0) return a;
        scale = ((lim - m) << 16) / lim;
        return 24'((64'(a) * scale) >> 16);
      end
      return 24'd0;
    end
    return a;
  endfunction

  // Advance the shadow by one accepted word; queue the bin it releases.
  function automatic void predict_bin(logic f, logic [23:0] a, logic [23:0] fr);
    int unsigned nb;
    int unsigned j;
    int unsigned slot;
    int unsigned idx;
    int unsigned c;
    logic        last;
    logic [23:0] d;
    logic [27:0] sum;
    logic [27:0] mean;
    gated_bin_t  r;
    nb   = (cfg_bins < 1) ? 1 :
           (cfg_bins > sfsg_pkg::MaxBins) ? sfsg_pkg::MaxBins : cfg_bins;
    j    = bin_pos % sfsg_pkg::MaxBins;
    last = bin_pos >= nb - 1;
    if (!f) begin
      slot = head_slot % sfsg_pkg::Window;
      idx  = slot * sfsg_pkg::MaxBins + j;
      d    = 0;
      sum  = 0;
      if (frames_held != 0) begin
        d   = (fr > prev_freq[j]) ? fr - prev_freq[j] : prev_freq[j] - fr;
        sum = dev_sum[j];
        if (frames_held >= sfsg_pkg::Window) sum = sum - 28'(held_diff[idx]);
        sum = sum + 28'(d);
      end
      if (frames_held >= sfsg_pkg::Window) begin
        mean   = 28'(sum / sfsg_pkg::Window);
        r.amp  = gate_amp(held_amp[idx], mean);
        r.freq = held_freq[idx];
        r.bin  = 10'(j);
        r.fend = last;
        r.dend = 1'b0;
        expected_bins.push_back(r);
      end
      held_amp[idx]  = a;
      held_freq[idx] = fr;
      held_diff[idx] = d;
      prev_freq[j]   = fr;
      dev_sum[j]     = sum;
      if (last) begin
        bin_pos   = 0;
        head_slot = (slot + 1) % sfsg_pkg::Window;
        if (frames_held < sfsg_pkg::Window) frames_held++;
      end else begin
        bin_pos++;
      end
      return;
    end
    // drain with nothing held drops any partial frame
    if (frames_held == 0) begin
      bin_pos = 0;
      return;
    end
    slot       = (head_slot % sfsg_pkg::Window + sfsg_pkg::Window - frames_held) %
                 sfsg_pkg::Window;
    idx        = slot * sfsg_pkg::MaxBins + j;
    sum        = dev_sum[j] - 28'(held_diff[idx]);
    dev_sum[j] = sum;
    c          = frames_held - 1;
    mean       = (c != 0) ? 28'(sum / c) : 28'd0;
    r.amp  = gate_amp(held_amp[idx], mean);
    r.freq = held_freq[idx];
    r.bin  = 10'(j);
    r.fend = last;
    r.dend = last && frames_held == 1;
    expected_bins.push_back(r);
    if (last) begin
      bin_pos = 0;
      frames_held--;
    end else begin
      bin_pos++;
    end
  endfunction

  // Send one word; return at the edge that accepts it.
  task automatic send_word(logic f, logic [23:0] a, logic [23:0] fr);
    logic taken;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    func      <= f;
    amplitude <= a;
    frequency <= fr;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_bin(f, a, fr);
    words_sent++;
  endtask

  // Let the block go idle, then write one register.
  task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sfsg_pkg::CfgBinCount) cfg_bins = 11'(val);
    else if (idx == sfsg_pkg::CfgGateMode) cfg_mode = 2'(val);
    else if (idx == sfsg_pkg::CfgFreqLimit) cfg_limit = val;
  endtask

  // Send full frames with per-bin frequency wander of up to +/- jitter,
  // then drain until the last held frame is out.
  task automatic run_stream(int frames, int unsigned jitter, bit extremes);
    int unsigned nb;
    int          b;
    int          k;
    longint      base[sfsg_pkg::MaxBins];
    longint      fq;
    logic [23:0] a;
    nb = (cfg_bins < 1) ? 1 :
         (cfg_bins > sfsg_pkg::MaxBins) ? sfsg_pkg::MaxBins : cfg_bins;
    for (b = 0; b < nb; b++) base[b] = $urandom_range(0, 24'hFFFFFF);
    for (k = 0; k < frames; k++) begin
      for (b = 0; b < nb; b++) begin
        fq = base[b] + longint'($urandom_range(0, 2 * jitter)) - jitter;
        if (fq < 0) fq = 0;
        if (fq > 24'hFFFFFF) fq = 24'hFFFFFF;
        a = 24'($urandom());
        if (extremes) begin
          a  = (k % 2) ? 24'hFFFFFF : 24'h0;
          fq = ((k + b) % 2) ? 24'hFFFFFF : 24'h0;
        end
        send_word(1'b0, a, 24'(fq));
      end
    end
    while (frames_held != 0) send_word(1'b1, 24'($urandom()), 24'($urandom()));
  endtask

  task automatic test_directed();
    send_word(1'b1, 24'h0, 24'h0);          // drain with nothing held
    cfg_write(sfsg_pkg::CfgBinCount, 24'd2);
    cfg_write(sfsg_pkg::CfgGateMode, 24'(sfsg_pkg::ModeStable));
    cfg_write(sfsg_pkg::CfgFreqLimit, 24'd1);
    run_stream(1, 0, 1'b1);                 // never leaves warm-up
    run_stream(7, 0, 1'b1);                 // extremes of both fields
    cfg_write(sfsg_pkg::CfgFreqLimit, 24'hFFFFFF);
    run_stream(7, 0, 1'b0);                 // zero mean passes in stable mode
  endtask

  task automatic test_modes();
    int m;
    for (m = 0; m < 4; m++) begin
      cfg_write(sfsg_pkg::CfgGateMode, 24'(m));
      cfg_write(sfsg_pkg::CfgFreqLimit, 24'd64);
      run_stream(8, 160, 1'b0);
      cfg_write(sfsg_pkg::CfgFreqLimit, 24'hFFFFFF);
      run_stream(7, 24'hFFFFFF, 1'b0);
    end
  endtask

  // Oversized bin count saturates to the widest frame; drop a long partial
  // frame, then return to short frames.
  task automatic test_widest_frame();
    int k;
    cfg_write(sfsg_pkg::CfgBinCount, 24'd2047);
    for (k = 0; k < 300; k++) send_word(1'b0, 24'($urandom()), 24'($urandom()));
    send_word(1'b1, 24'($urandom()), 24'($urandom()));
    cfg_write(sfsg_pkg::CfgBinCount, 24'd4);
  endtask

  task automatic test_random();
    int unsigned lim;
    int          k;
    int          n;
    while (words_sent < ItemTarget) begin
      if ($urandom_range(0, 2) == 0)
        cfg_write(sfsg_pkg::CfgBinCount, 24'($urandom_range(2, 9)));
      if ($urandom_range(0, 2) == 0)
        cfg_write(sfsg_pkg::CfgGateMode, 24'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: lim = 1;
          1: lim = 24'hFFFFFF;
          default: lim = 1 << $urandom_range(0, 23);
        endcase
        cfg_write(sfsg_pkg::CfgFreqLimit, 24'(lim));
      end
      lim = (cfg_limit == 0) ? 1 : cfg_limit;
      // drop a partial frame now and then
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(0, cfg_bins - 1);
        for (k = 0; k < n; k++) send_word(1'b0, 24'($urandom()), 24'($urandom()));
        send_word(1'b1, 24'($urandom()), 24'($urandom()));
      end
      run_stream($urandom_range(1, 12),
                 (lim > 24'h3FFFFF) ? 24'hFFFFFF : lim * $urandom_range(1, 4),
                 1'b0);
    end
  endtask

  // Receiver: alternate free-running and stall-heavy stretches.
  int stall_run;
  int stall_kind;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run  <= $urandom_range(5, 60);
      stall_kind <= $urandom_range(0, 2);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_kind)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Check each accepted output word against the oldest expectation.
  always @(negedge clk) begin
    gated_bin_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: amp %h freq %h bin %0d fend %b dend %b",
                   amp_out, freq_out, bin_out, frame_end, data_end);
      end else begin
        e = expected_bins.pop_front();
        if (amp_out !== e.amp || freq_out !== e.freq || bin_out !== e.bin ||
            frame_end !== e.fend || data_end !== e.dend) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h/%h/%0d/%b/%b got %h/%h/%0d/%b/%b",
                     e.amp, e.freq, e.bin, e.fend, e.dend,
                     amp_out, freq_out, bin_out, frame_end, data_end);
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    func        = 1'b0;
    amplitude   = '0;
    frequency   = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = sfsg_pkg::CfgBinCount;
    cfg_data    = '0;
    stall_run   = 0;
    stall_kind  = 0;
    mismatches  = 0;
    words_sent  = 0;
    burst_left  = 0;
    bin_pos     = 0;
    frames_held = 0;
    head_slot   = 0;
    cfg_bins    = 11'd513;
    cfg_mode    = 2'd0;
    cfg_limit   = 24'd256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_modes();
    test_widest_frame();
    test_random();
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
